// File: rtl/rcfe_pkg.sv
// Shared types, constants and the CRC-8 step for the RC-channels frame encoder.
package rcfe_pkg;

  localparam int unsigned VAL_W      = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned PCNT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hC8;
  localparam logic [BYTE_W-1:0] LEN_BYTE  = 8'd24;
  localparam logic [BYTE_W-1:0] TYPE_BYTE = 8'h16;
  localparam logic [BYTE_W-1:0] CRC_POLY  = 8'hD5;

  localparam logic [VAL_W-1:0] LOW_RESET  = 11'd172;
  localparam logic [VAL_W-1:0] HIGH_RESET = 11'd1811;

  localparam logic [CH_W-1:0] CH_FIRST = 4'd0;
  localparam logic [CH_W-1:0] CH_LAST  = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 2'd1;

  // One classified channel word handed from the front to the back
  typedef struct packed {
    logic              first;     // send sync, length and type ahead of payload
    logic              crc_last;  // close the frame with the CRC byte
    logic              two;       // two payload bytes instead of one
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
  } rcfe_entry_t;

  // Queue status seen by the front, the back and the checks
  typedef struct packed {
    logic full;
    logic empty;
  } rcfe_fifo_stat_t;

  // Feed one byte into the CRC-8, MSB first, no reflection
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/rc_channels_frame_encoder.sv
// Top level of the RC-channels frame encoder: front, queue and byte serializer.
//
// Takes sixteen 11-bit channel words per frame, clamps each to the configured
// bounds, packs them LSB first and sends a 26-byte frame (sync, length, type,
// 22 payload bytes, CRC-8 poly 0xD5) one byte per cycle while the consumer is ready.
// Each input word yields 1 to 4 output bytes: 4 for channel 0 (header plus one
// payload byte), 3 for channel 15 (two payload bytes plus CRC), 1 or 2 otherwise.
// The output serializer, which moves one byte per cycle when not stalled, sets
// the sustained rate; the front accepts a word every cycle while the queue has
// room (QUEUE_DEPTH words) and the output register decouples the consumer.
// Configuration writes are always accepted and should occur while idle.
module rc_channels_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = rcfe_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rcfe_pkg::VAL_W-1:0]      in_channel_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rcfe_pkg::BYTE_W-1:0]     out_data_byte,
  output logic                            out_last_of_run,
  output logic                            out_end_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcfe_pkg::VAL_W-1:0]      cfg_data
);

  rcfe_pkg::rcfe_entry_t     push_entry, head;
  rcfe_pkg::rcfe_fifo_stat_t q_stat;
  logic                      q_push, q_pop;

  assign cfg_ready = 1'b1;

  rcfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_value (in_channel_value),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  rcfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .stat       (q_stat)
  );

  rcfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

`ifndef SYNTHESIS
  // The CRC byte always closes the run of its word
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_last_of_run)
    else $error("CRC byte not marked last of run");

  // Pop only a present word
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // Queue cannot read both full and empty
  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");
`endif

endmodule

// File: rtl/rcfe_front.sv
// Front end: configuration registers, clamping and bit packing of channel words.
module rcfe_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rcfe_pkg::VAL_W-1:0]         in_channel_value,
  input  logic                               cfg_valid,
  input  logic [rcfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcfe_pkg::VAL_W-1:0]         cfg_data,
  input  rcfe_pkg::rcfe_fifo_stat_t          q_stat,
  output logic                               q_push,
  output rcfe_pkg::rcfe_entry_t              q_entry
);

  logic [rcfe_pkg::VAL_W-1:0]  clamp_low_r;
  logic [rcfe_pkg::VAL_W-1:0]  clamp_high_r;
  logic [rcfe_pkg::CH_W-1:0]   ch_cnt_r;
  logic [rcfe_pkg::PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [rcfe_pkg::PCNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  logic [rcfe_pkg::VAL_W-1:0]  v_raised, v_clamped;
  logic                        first, last_ch, two;
  logic [rcfe_pkg::PEND_W-1:0] pend_in;
  logic [rcfe_pkg::PCNT_W-1:0] pcnt_in;
  logic [17:0]                 acc;
  logic [4:0]                  bits;

  // Accept while the queue has room
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  // Raise to the low bound first, then limit to the high bound
  assign v_raised  = (in_channel_value < clamp_low_r) ? clamp_low_r : in_channel_value;
  assign v_clamped = (v_raised > clamp_high_r) ? clamp_high_r : v_raised;

  // Append the 11-bit field LSB first behind the pending bits
  assign first   = (ch_cnt_r == rcfe_pkg::CH_FIRST);
  assign last_ch = (ch_cnt_r == rcfe_pkg::CH_LAST);
  assign pend_in = first ? '0 : pend_bits_r;
  assign pcnt_in = first ? '0 : pend_cnt_r;
  assign acc     = {11'd0, pend_in} | ({7'd0, v_clamped} << pcnt_in);
  assign bits    = {2'd0, pcnt_in} + 5'd11;
  assign two     = (bits >= 5'd16);

  always_comb begin
    if (last_ch) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end else if (two) begin
      pend_bits_nxt = {5'd0, acc[17:16]};
      pend_cnt_nxt  = 3'(bits - 5'd16);
    end else begin
      pend_bits_nxt = acc[14:8];
      pend_cnt_nxt  = 3'(bits - 5'd8);
    end
  end

  always_comb begin
    q_entry.first    = first;
    q_entry.crc_last = last_ch;
    q_entry.two      = two;
    q_entry.b0       = acc[7:0];
    q_entry.b1       = acc[15:8];
  end

  // Hold the clamp bounds; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_low_r  <= rcfe_pkg::LOW_RESET;
      clamp_high_r <= rcfe_pkg::HIGH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcfe_pkg::REG_CLAMP_LOW:  clamp_low_r  <= cfg_data;
        rcfe_pkg::REG_CLAMP_HIGH: clamp_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance channel and packing state per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r    <= '0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (q_push) begin
      ch_cnt_r    <= ch_cnt_r + 4'd1;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

// File: rtl/rcfe_fifo.sv
// Short queue of classified channel words between front and back.
module rcfe_fifo #(
  parameter int unsigned DEPTH = rcfe_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rcfe_pkg::rcfe_entry_t     push_entry,
  input  logic                      pop,
  output rcfe_pkg::rcfe_entry_t     head,
  output rcfe_pkg::rcfe_fifo_stat_t stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rcfe_pkg::rcfe_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/rcfe_back.sv
// Back end: serializes queued words into frame bytes and keeps the running CRC.
module rcfe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcfe_pkg::rcfe_entry_t         head,
  input  rcfe_pkg::rcfe_fifo_stat_t     q_stat,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcfe_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                          out_last_of_run,
  output logic                          out_end_of_frame
);

  typedef enum logic [2:0] {
    K_SYNC, K_LEN, K_TYPE, K_PAY0, K_PAY1, K_CRC
  } kind_t;

  logic [1:0]                 step_r;
  logic [rcfe_pkg::BYTE_W-1:0] crc_r;
  logic                       out_valid_r;
  logic [rcfe_pkg::BYTE_W-1:0] out_data_r;
  logic                       out_last_r;
  logic                       out_eof_r;

  kind_t                       kind;
  logic [2:0]                  n_bytes, hdr_n, pay_off;
  logic                        is_last, load;
  logic [rcfe_pkg::BYTE_W-1:0] byte_sel, crc_base, crc_fed;

  // Count bytes this word yields and place the current step
  assign hdr_n   = head.first ? 3'd3 : 3'd0;
  assign n_bytes = hdr_n + (head.two ? 3'd2 : 3'd1) + {2'd0, head.crc_last};
  assign pay_off = {1'b0, step_r} - hdr_n;
  assign is_last = (({1'b0, step_r} + 3'd1) == n_bytes);
  assign load    = !q_stat.empty && (!out_valid_r || out_ready);
  assign q_pop   = load && is_last;

  always_comb begin
    priority if (head.first && step_r == 2'd0) begin
      kind = K_SYNC;
    end else if (head.first && step_r == 2'd1) begin
      kind = K_LEN;
    end else if (head.first && step_r == 2'd2) begin
      kind = K_TYPE;
    end else if (pay_off == 3'd0) begin
      kind = K_PAY0;
    end else if (pay_off == 3'd1 && head.two) begin
      kind = K_PAY1;
    end else begin
      kind = K_CRC;
    end
  end

  // Select the byte for this step
  always_comb begin
    unique case (kind)
      K_SYNC:  byte_sel = rcfe_pkg::SYNC_BYTE;
      K_LEN:   byte_sel = rcfe_pkg::LEN_BYTE;
      K_TYPE:  byte_sel = rcfe_pkg::TYPE_BYTE;
      K_PAY0:  byte_sel = head.b0;
      K_PAY1:  byte_sel = head.b1;
      K_CRC:   byte_sel = crc_r;
      default: byte_sel = crc_r;
    endcase
  end

  // The type byte restarts the CRC from zero
  assign crc_base = (kind == K_TYPE) ? '0 : crc_r;
  assign crc_fed  = rcfe_pkg::crc8_feed(crc_base, byte_sel);

  // Advance step counter and CRC on each loaded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      crc_r  <= '0;
    end else if (load) begin
      step_r <= is_last ? 2'd0 : step_r + 2'd1;
      unique case (kind)
        K_TYPE, K_PAY0, K_PAY1: crc_r <= crc_fed;
        K_CRC:                  crc_r <= '0;
        K_SYNC, K_LEN:          crc_r <= crc_r;
        default:                crc_r <= crc_r;
      endcase
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= byte_sel;
      out_last_r <= is_last;
      out_eof_r  <= (kind == K_CRC);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_frame = out_eof_r;

endmodule

// File: test/rcfe_frame_check_pkg.sv
// Frame byte predictor and checker for the RC-channels frame encoder testbench.
package rcfe_frame_check_pkg;
  import rcfe_pkg::*;

  // One frame byte as seen on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              eof;
  } frame_byte_t;

  class frame_tracker;
    logic [VAL_W-1:0]  clamp_lo;
    logic [VAL_W-1:0]  clamp_hi;
    logic [CH_W-1:0]   ch_idx;
    logic [PEND_W-1:0] carry_bits;
    logic [PCNT_W-1:0] carry_cnt;
    logic [BYTE_W-1:0] crc;
    frame_byte_t       awaited[$];
    int unsigned       errors;
    int unsigned       words;
    int unsigned       bytes_seen;
    int unsigned       frames;

    function new();
      clamp_lo   = LOW_RESET;
      clamp_hi   = HIGH_RESET;
      ch_idx     = CH_FIRST;
      carry_bits = '0;
      carry_cnt  = '0;
      crc        = '0;
      errors     = 0;
      words      = 0;
      bytes_seen = 0;
      frames     = 0;
    endfunction

    // Track a register write; spare indexes leave the bounds alone
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      if (idx == REG_CLAMP_LOW) begin
        clamp_lo = val;
      end else if (idx == REG_CLAMP_HIGH) begin
        clamp_hi = val;
      end
    endfunction

    // CRC-8 over one byte, MSB first
    function logic [BYTE_W-1:0] crc_step(logic [BYTE_W-1:0] cur, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = cur ^ b;
      repeat (BYTE_W) begin
        if (r[BYTE_W-1]) begin
          r = {r[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
        end else begin
          r = {r[BYTE_W-2:0], 1'b0};
        end
      end
      return r;
    endfunction

    // Work out the bytes one accepted channel word causes and queue them
    function void note_channel(logic [VAL_W-1:0] raw);
      logic [VAL_W-1:0]  v;
      logic [17:0]       acc;
      int unsigned       nbits;
      frame_byte_t       run[$];
      v = raw;
      // raise first, then lower: an inverted range gives clamp_hi
      if (v < clamp_lo) begin
        v = clamp_lo;
      end
      if (v > clamp_hi) begin
        v = clamp_hi;
      end
      // open the frame with sync, length and type
      if (ch_idx == CH_FIRST) begin
        run.push_back({SYNC_BYTE, 1'b0, 1'b0});
        run.push_back({LEN_BYTE, 1'b0, 1'b0});
        run.push_back({TYPE_BYTE, 1'b0, 1'b0});
        crc        = crc_step('0, TYPE_BYTE);
        carry_bits = '0;
        carry_cnt  = '0;
      end
      // append the 11-bit field LSB first and peel off whole bytes
      acc   = 18'(carry_bits) | (18'(v) << carry_cnt);
      nbits = carry_cnt + VAL_W;
      while (nbits >= BYTE_W) begin
        run.push_back({acc[7:0], 1'b0, 1'b0});
        crc   = crc_step(crc, acc[7:0]);
        acc   = acc >> 8;
        nbits = nbits - BYTE_W;
      end
      carry_bits = acc[PEND_W-1:0];
      carry_cnt  = nbits[PCNT_W-1:0];
      // close the frame with the CRC byte
      if (ch_idx == CH_LAST) begin
        run.push_back({crc, 1'b0, 1'b1});
        carry_bits = '0;
        carry_cnt  = '0;
        crc        = '0;
      end
      ch_idx = ch_idx + 1'b1;
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) begin
        awaited.push_back(run[i]);
      end
      words++;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one output word against the oldest queued byte
    task check_byte(logic [BYTE_W-1:0] d, logic l, logic e);
      frame_byte_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b eof %0b", d, l, e));
        return;
      end
      want = awaited.pop_front();
      bytes_seen++;
      if (want.eof) begin
        frames++;
      end
      if (d !== want.data || l !== want.last || e !== want.eof) begin
        report($sformatf("byte %0d: got %02h last %0b eof %0b, want %02h last %0b eof %0b",
                         bytes_seen, d, l, e, want.data, want.last, want.eof));
      end
    endtask
  endclass

endpackage

// File: test/rc_channels_frame_encoder_test.sv
// Top-level testbench for the RC-channels frame encoder.
module rc_channels_frame_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rcfe_pkg::*;
  import rcfe_frame_check_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned RAND_PHASES     = 6;
  localparam int unsigned WORDS_PER_PHASE = 48;
  localparam int unsigned VAL_MAX         = 2047;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     in_channel_value = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [BYTE_W-1:0]    out_data_byte;
  logic                 out_last_of_run;
  logic                 out_end_of_frame;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [VAL_W-1:0]     cfg_data         = '0;

  int unsigned  send_gap_pct = 14;
  int unsigned  recv_gap_pct = 70;
  int unsigned  cfg_writes   = 0;
  int unsigned  quiet_cycles = 0;
  frame_tracker sb;

  rc_channels_frame_encoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_value (in_channel_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_byte(out_data_byte, out_last_of_run, out_end_of_frame);
    end
  end

  // Abort when no channel moves a word for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[rc_channels_frame_encoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one channel word, hold it until taken, then maybe idle
  task automatic send_value(input logic [VAL_W-1:0] v);
    in_valid         <= 1'b1;
    in_channel_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_channel(v);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
  endtask

  task automatic end_words();
    in_valid <= 1'b0;
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Mix full-range values with values around the bounds and the extremes
  function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] lo,
                                                  input logic [VAL_W-1:0] hi);
    int r;
    int base;
    r = $urandom_range(9);
    if (r < 4) begin
      return VAL_W'($urandom_range(VAL_MAX));
    end else if (r == 9) begin
      return ($urandom_range(1) != 0) ? VAL_W'(VAL_MAX) : '0;
    end
    base = (r < 7) ? int'(lo) : int'(hi);
    base = base + int'($urandom_range(6)) - 3;
    if (base < 0) begin
      base = 0;
    end else if (base > int'(VAL_MAX)) begin
      base = VAL_MAX;
    end
    return VAL_W'(base);
  endfunction

  initial begin
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    int               p;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one full frame at the reset bounds, edges around them
    send_value(11'd0);
    send_value(11'd2047);
    send_value(11'd171);
    send_value(11'd172);
    send_value(11'd173);
    send_value(11'd1810);
    send_value(11'd1811);
    send_value(11'd1812);
    send_value(11'd1024);
    send_value(11'h555);
    send_value(11'h2AA);
    send_value(11'd1);
    send_value(11'd2046);
    send_value(11'd992);
    send_value(11'h7F0);
    send_value(11'h00F);
    end_words();
    wait_drained();

    // Directed: inverted range forces every value to the high bound
    write_reg(REG_CLAMP_LOW, 11'd2047);
    write_reg(REG_CLAMP_HIGH, 11'd0);
    write_reg(REG_SPARE_2, 11'h555);
    cfg_done();
    send_value(11'd0);
    send_value(11'd1024);
    send_value(11'd2047);
    end_words();
    wait_drained();

    // Directed: open range passes everything
    write_reg(REG_CLAMP_LOW, 11'd0);
    write_reg(REG_CLAMP_HIGH, 11'd2047);
    write_reg(REG_SPARE_3, 11'h2AA);
    cfg_done();
    send_value(11'd0);
    send_value(11'd2047);
    send_value(11'h555);
    send_value(11'h2AA);
    send_value(11'd1);
    end_words();
    wait_drained();

    // Random phases: slow receiver, then slow sender, then no idling
    for (p = 0; p < RAND_PHASES; p++) begin
      send_gap_pct = (p < 2) ? 14 : (p < 4) ? 70 : 0;
      recv_gap_pct = (p < 2) ? 70 : (p < 4) ? 14 : 0;
      case (p)
        0: begin
          write_reg(REG_CLAMP_LOW, 11'd0);
          write_reg(REG_CLAMP_HIGH, 11'd2047);
          write_reg(REG_SPARE_2, VAL_W'($urandom_range(VAL_MAX)));
        end
        1: begin
          lo = VAL_W'($urandom_range(1023));
          hi = VAL_W'($urandom_range(VAL_MAX, 1024));
          write_reg(REG_CLAMP_LOW, lo);
          write_reg(REG_CLAMP_HIGH, hi);
        end
        3: begin
          write_reg(REG_CLAMP_LOW, LOW_RESET);
          write_reg(REG_CLAMP_HIGH, HIGH_RESET);
          write_reg(REG_SPARE_3, VAL_W'($urandom_range(VAL_MAX)));
        end
        4: begin
          lo = VAL_W'($urandom_range(VAL_MAX));
          write_reg(REG_CLAMP_LOW, lo);
          write_reg(REG_CLAMP_HIGH, lo);
        end
        default: begin
          write_reg(REG_CLAMP_LOW, VAL_W'($urandom_range(VAL_MAX)));
          write_reg(REG_CLAMP_HIGH, VAL_W'($urandom_range(VAL_MAX)));
        end
      endcase
      cfg_done();
      repeat (WORDS_PER_PHASE) send_value(pick_value(sb.clamp_lo, sb.clamp_hi));
      end_words();
      wait_drained();
    end

    // Let any stray output show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d channel words under %0d register writes and 9 bound settings",
             sb.words, cfg_writes);
    $display("checked %0d frame bytes, %0d complete frames, %0d mismatches",
             sb.bytes_seen, sb.frames, sb.errors);
    if (sb.errors == 0) begin
      $display("[rc_channels_frame_encoder] OK");
    end else begin
      $display("[rc_channels_frame_encoder] ERROR");
    end
    $finish;
  end

endmodule
